>>> design/gec_pkg.sv
// ----------------------------------------------------------------------------
// gec_pkg
// Shared constants, event codes and controller/datapath interface types
// for the gamepad event conditioner.
// ----------------------------------------------------------------------------
package gec_pkg;

    localparam int MAX_AXES    = 8;
    localparam int MAX_HATS    = 4;
    localparam int MAX_BUTTONS = 16;
    localparam int SLOT_DEPTH  = 16;

    localparam logic signed [15:0] FULL_SCALE     = 16'sd32767;
    localparam logic signed [15:0] NEG_FULL_SCALE = -16'sd32767;
    localparam logic signed [15:0] MOST_NEG       = -16'sd32768;

    // event codes
    localparam logic [2:0] MODE_AXIS     = 3'd0;
    localparam logic [2:0] MODE_BTN_DOWN = 3'd1;
    localparam logic [2:0] MODE_BTN_UP   = 3'd2;
    localparam logic [2:0] MODE_HAT      = 3'd3;
    localparam logic [2:0] MODE_TICK     = 3'd4;
    localparam logic [2:0] MODE_ATTACH   = 3'd5;
    localparam logic [2:0] MODE_DETACH   = 3'd6;

    // register indexes
    localparam logic [2:0] REG_DEADZONE  = 3'd0;
    localparam logic [2:0] REG_GAIN      = 3'd1;
    localparam logic [2:0] REG_STICKY    = 3'd2;
    localparam logic [2:0] REG_PERIOD    = 3'd3;
    localparam logic [2:0] REG_AXES      = 3'd4;
    localparam logic [2:0] REG_BUTTONS   = 3'd5;
    localparam logic [2:0] REG_HATS      = 3'd6;
    localparam logic [2:0] REG_DEVICE    = 3'd7;

    // register reset values
    localparam logic [14:0] DEADZONE_RST = 15'd1638;
    localparam logic [19:0] GAIN_RST     = 20'd68985;
    localparam logic [15:0] PERIOD_RST   = 16'd20;
    localparam logic [3:0]  AXES_RST     = 4'd8;
    localparam logic [4:0]  BUTTONS_RST  = 5'd16;
    localparam logic [2:0]  HATS_RST     = 3'd0;
    localparam logic [7:0]  DEVICE_RST   = 8'd0;

    typedef struct packed {
        logic latch;
        logic btn_upd;
        logic hat_h;
        logic hat_v;
        logic ax_wr;
        logic tick;
        logic pub_start;
        logic attach;
        logic detach;
        logic rd_pub;
        logic out_load;
    } gec_cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       attached;
        logic       mine;
        logic       axis_ok;
        logic       btn_ok;
        logic       hat_ok;
        logic       attach_ok;
        logic       tick_pub;
        logic       pub_empty;
        logic       pub_last;
        logic       out_free;
    } gec_status_t;

endpackage

>>> design/gec_ctrl.sv
// ----------------------------------------------------------------------------
// gec_ctrl
// Sequencer: decodes each item and steps the datapath through axis
// conditioning, hat writes and snapshot publication.
// ----------------------------------------------------------------------------
module gec_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gec_pkg::gec_status_t sts,
    output gec_pkg::gec_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_DECODE   = 8'b0000_0010,
        ST_AX_MUL   = 8'b0000_0100,
        ST_AX_WR    = 8'b0000_1000,
        ST_HAT_V    = 8'b0001_0000,
        ST_PUB_RD   = 8'b0010_0000,
        ST_PUB_LOAD = 8'b0100_0000,
        ST_SPARE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                unique case (sts.mode)
                    gec_pkg::MODE_AXIS:
                    begin
                        if (sts.mine && sts.axis_ok)
                        begin
                            state_next = ST_AX_MUL;
                        end
                    end
                    gec_pkg::MODE_BTN_DOWN, gec_pkg::MODE_BTN_UP:
                    begin
                        cmd.btn_upd = sts.mine && sts.btn_ok;
                    end
                    gec_pkg::MODE_HAT:
                    begin
                        if (sts.mine && sts.hat_ok)
                        begin
                            cmd.hat_h  = 1'b1;
                            state_next = ST_HAT_V;
                        end
                    end
                    gec_pkg::MODE_TICK:
                    begin
                        if (sts.attached)
                        begin
                            cmd.tick = 1'b1;
                            if (sts.tick_pub)
                            begin
                                cmd.pub_start = 1'b1;
                                if (!sts.pub_empty)
                                begin
                                    state_next = ST_PUB_RD;
                                end
                            end
                        end
                    end
                    gec_pkg::MODE_ATTACH:
                    begin
                        if (sts.attach_ok)
                        begin
                            cmd.attach    = 1'b1;
                            cmd.pub_start = 1'b1;
                            if (!sts.pub_empty)
                            begin
                                state_next = ST_PUB_RD;
                            end
                        end
                    end
                    gec_pkg::MODE_DETACH:
                    begin
                        cmd.detach = sts.mine;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_AX_MUL:
            begin
                state_next = ST_AX_WR;
            end
            ST_AX_WR:
            begin
                cmd.ax_wr  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_HAT_V:
            begin
                cmd.hat_v  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_PUB_RD:
            begin
                cmd.rd_pub = 1'b1;
                state_next = ST_PUB_LOAD;
            end
            ST_PUB_LOAD:
            begin
                cmd.rd_pub = 1'b1;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sts.pub_last ? ST_IDLE : ST_PUB_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/gec_datapath.sv
// ----------------------------------------------------------------------------
// gec_datapath
// Configuration registers, axis conditioning (deadzone, gain, rounding,
// saturation), snapshot store and the output register.
// ----------------------------------------------------------------------------
module gec_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [19:0]          cfg_data,
    input  logic [2:0]           mode,
    input  logic [7:0]           source_id,
    input  logic [7:0]           element_index,
    input  logic signed [15:0]   sample_value,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 element_kind,
    output logic [3:0]           element_number,
    output logic signed [15:0]   element_value,
    output logic                 last_element,
    input  gec_pkg::gec_cmd_t    cmd,
    output gec_pkg::gec_status_t sts
);

    // configuration
    logic [14:0] deadzone_reg;
    logic [19:0] gain_reg;
    logic        sticky_reg;
    logic [15:0] period_reg;
    logic [3:0]  axes_reg;
    logic [4:0]  buttons_reg;
    logic [2:0]  hats_reg;
    logic [7:0]  device_reg;

    // latched item
    logic [2:0]         mode_reg;
    logic [7:0]         inst_reg;
    logic [7:0]         idx_reg;
    logic signed [15:0] sample_reg;

    // snapshot state
    logic signed [15:0] axis_mem [gec_pkg::SLOT_DEPTH];
    logic [gec_pkg::SLOT_DEPTH-1:0] axis_valid_reg;
    logic [gec_pkg::SLOT_DEPTH-1:0] btn_reg;
    logic        attached_reg;
    logic [7:0]  active_reg;
    logic        pending_reg;
    logic [15:0] ticks_reg;
    logic [5:0]  pub_k_reg;

    logic signed [15:0] rd_data_reg;
    logic               rd_valid_reg;

    // axis pipeline
    logic [14:0] adj_mag_reg;
    logic        adj_neg_out_reg;
    logic [34:0] prod_reg;

    // output register
    logic               out_valid_reg;
    logic               kind_reg;
    logic [3:0]         number_reg;
    logic signed [15:0] value_reg;
    logic               last_reg;

    // effective device shape
    logic [5:0] eff_axes;
    logic [3:0] eff_hats;
    logic [5:0] slots_raw;
    logic [4:0] eff_slots;
    logic [5:0] btn_raw;
    logic [4:0] eff_btns;
    logic [5:0] total;

    always_comb
    begin
        eff_axes  = ({2'b0, axes_reg} < 6'(gec_pkg::MAX_AXES)) ?
                    {2'b0, axes_reg} : 6'(gec_pkg::MAX_AXES);
        eff_hats  = ({1'b0, hats_reg} < 4'(gec_pkg::MAX_HATS)) ?
                    {1'b0, hats_reg} : 4'(gec_pkg::MAX_HATS);
        slots_raw = eff_axes + {1'b0, eff_hats, 1'b0};
        eff_slots = (slots_raw < 6'(gec_pkg::SLOT_DEPTH)) ?
                    slots_raw[4:0] : 5'(gec_pkg::SLOT_DEPTH);
        btn_raw   = ({1'b0, buttons_reg} < 6'(gec_pkg::MAX_BUTTONS)) ?
                    {1'b0, buttons_reg} : 6'(gec_pkg::MAX_BUTTONS);
        eff_btns  = (btn_raw < 6'(gec_pkg::SLOT_DEPTH)) ?
                    btn_raw[4:0] : 5'(gec_pkg::SLOT_DEPTH);
        total     = {1'b0, eff_slots} + {1'b0, eff_btns};
    end

    // deadzone on the latched sample
    logic signed [15:0] clamped;
    logic [14:0]        abs_v;
    logic [14:0]        mag;

    always_comb
    begin
        clamped = (sample_reg == gec_pkg::MOST_NEG) ? gec_pkg::NEG_FULL_SCALE : sample_reg;
        abs_v   = clamped[15] ? 15'(-clamped) : clamped[14:0];
        mag     = (abs_v > deadzone_reg) ? (abs_v - deadzone_reg) : 15'd0;
    end

    // rounding and saturation
    logic [35:0]        rnd_sum;
    logic [19:0]        r_full;
    logic [14:0]        r_sat;
    logic signed [15:0] cond_val;
    logic signed [15:0] old_val;

    always_comb
    begin
        rnd_sum  = {1'b0, prod_reg} + 36'd32768;
        r_full   = rnd_sum[35:16];
        r_sat    = (r_full > 20'(gec_pkg::FULL_SCALE)) ? gec_pkg::FULL_SCALE[14:0] : r_full[14:0];
        cond_val = adj_neg_out_reg ? -$signed({1'b0, r_sat}) : $signed({1'b0, r_sat});
        old_val  = rd_valid_reg ? rd_data_reg : 16'sd0;
    end

    // hat slots
    logic [5:0]         hat_first;
    logic [5:0]         hat_second;
    logic signed [15:0] hat_h_val;
    logic signed [15:0] hat_v_val;

    always_comb
    begin
        hat_first  = eff_axes + {1'b0, idx_reg[3:0], 1'b0};
        hat_second = hat_first + 6'd1;
        hat_h_val  = sample_reg[3] ? gec_pkg::FULL_SCALE :
                     (sample_reg[1] ? gec_pkg::NEG_FULL_SCALE : 16'sd0);
        hat_v_val  = sample_reg[0] ? gec_pkg::FULL_SCALE :
                     (sample_reg[2] ? gec_pkg::NEG_FULL_SCALE : 16'sd0);
    end

    // store write and read port
    logic               wr_en;
    logic [3:0]         wr_addr;
    logic signed [15:0] wr_data;
    logic [3:0]         rd_addr;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[3:0];
        wr_data = cond_val;
        if (cmd.ax_wr && (cond_val != old_val))
        begin
            wr_en = 1'b1;
        end
        else if (cmd.hat_h)
        begin
            wr_en   = hat_first < 6'(gec_pkg::SLOT_DEPTH);
            wr_addr = hat_first[3:0];
            wr_data = hat_h_val;
        end
        else if (cmd.hat_v)
        begin
            wr_en   = hat_second < 6'(gec_pkg::SLOT_DEPTH);
            wr_addr = hat_second[3:0];
            wr_data = hat_v_val;
        end
        rd_addr = cmd.rd_pub ? pub_k_reg[3:0] : idx_reg[3:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            axis_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= axis_mem[rd_addr];
    end

    // ticks and publication
    logic [15:0] ticks_inc;
    logic [5:0]  btn_k;
    logic        btn_level;
    logic        is_axis_elem;

    always_comb
    begin
        ticks_inc    = (ticks_reg == 16'hFFFF) ? ticks_reg : (ticks_reg + 16'd1);
        btn_k        = pub_k_reg - {1'b0, eff_slots};
        btn_level    = (mode_reg == gec_pkg::MODE_BTN_DOWN);
        is_axis_elem = pub_k_reg < {1'b0, eff_slots};
    end

    // item latch and pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            inst_reg   <= source_id;
            idx_reg    <= element_index;
            sample_reg <= sample_value;
        end
        adj_mag_reg     <= mag;
        adj_neg_out_reg <= !clamped[15];
        prod_reg        <= {20'd0, adj_mag_reg} * {15'd0, gain_reg};
        if (cmd.out_load)
        begin
            kind_reg   <= !is_axis_elem;
            number_reg <= is_axis_elem ? pub_k_reg[3:0] : btn_k[3:0];
            value_reg  <= is_axis_elem ? (rd_valid_reg ? rd_data_reg : 16'sd0) :
                          $signed({15'd0, btn_reg[btn_k[3:0]]});
            last_reg   <= (pub_k_reg + 6'd1) == total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg   <= gec_pkg::DEADZONE_RST;
            gain_reg       <= gec_pkg::GAIN_RST;
            sticky_reg     <= 1'b0;
            period_reg     <= gec_pkg::PERIOD_RST;
            axes_reg       <= gec_pkg::AXES_RST;
            buttons_reg    <= gec_pkg::BUTTONS_RST;
            hats_reg       <= gec_pkg::HATS_RST;
            device_reg     <= gec_pkg::DEVICE_RST;
            mode_reg       <= gec_pkg::MODE_AXIS;
            axis_valid_reg <= '0;
            btn_reg        <= '0;
            attached_reg   <= 1'b0;
            active_reg     <= 8'd0;
            pending_reg    <= 1'b0;
            ticks_reg      <= 16'd0;
            pub_k_reg      <= 6'd0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gec_pkg::REG_DEADZONE: deadzone_reg <= cfg_data[14:0];
                    gec_pkg::REG_GAIN:     gain_reg     <= cfg_data;
                    gec_pkg::REG_STICKY:   sticky_reg   <= cfg_data[0];
                    gec_pkg::REG_PERIOD:   period_reg   <= cfg_data[15:0];
                    gec_pkg::REG_AXES:     axes_reg     <= cfg_data[3:0];
                    gec_pkg::REG_BUTTONS:  buttons_reg  <= cfg_data[4:0];
                    gec_pkg::REG_HATS:     hats_reg     <= cfg_data[2:0];
                    gec_pkg::REG_DEVICE:   device_reg   <= cfg_data[7:0];
                    default:               device_reg   <= device_reg;
                endcase
            end

            if (cmd.latch)
            begin
                mode_reg <= mode;
            end

            rd_valid_reg <= axis_valid_reg[rd_addr];

            if (wr_en)
            begin
                axis_valid_reg[wr_addr] <= 1'b1;
                pending_reg             <= 1'b1;
            end
            if (cmd.hat_h)
            begin
                pending_reg <= 1'b1;
            end

            if (cmd.btn_upd)
            begin
                if (sticky_reg)
                begin
                    if (btn_level)
                    begin
                        btn_reg[idx_reg[3:0]] <= !btn_reg[idx_reg[3:0]];
                        pending_reg           <= 1'b1;
                    end
                end
                else if (btn_reg[idx_reg[3:0]] != btn_level)
                begin
                    btn_reg[idx_reg[3:0]] <= btn_level;
                    pending_reg           <= 1'b1;
                end
            end

            if (cmd.tick)
            begin
                ticks_reg <= ticks_inc;
            end

            if (cmd.attach)
            begin
                axis_valid_reg <= '0;
                btn_reg        <= '0;
                attached_reg   <= 1'b1;
                active_reg     <= inst_reg;
            end

            if (cmd.pub_start)
            begin
                ticks_reg   <= 16'd0;
                pending_reg <= 1'b0;
                pub_k_reg   <= 6'd0;
            end
            else if (cmd.out_load)
            begin
                pub_k_reg <= pub_k_reg + 6'd1;
            end

            if (cmd.detach)
            begin
                axis_valid_reg <= '0;
                btn_reg        <= '0;
                attached_reg   <= 1'b0;
                active_reg     <= 8'd0;
                pending_reg    <= 1'b0;
                ticks_reg      <= 16'd0;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.mode      = mode_reg;
        sts.attached  = attached_reg;
        sts.mine      = attached_reg && (inst_reg == active_reg);
        sts.axis_ok   = idx_reg < {3'd0, eff_slots};
        sts.btn_ok    = idx_reg < {3'd0, eff_btns};
        sts.hat_ok    = idx_reg < {4'd0, eff_hats};
        sts.attach_ok = !attached_reg && (idx_reg == device_reg);
        sts.tick_pub  = pending_reg || ((period_reg != 16'd0) && (ticks_inc >= period_reg));
        sts.pub_empty = total == 6'd0;
        sts.pub_last  = (pub_k_reg + 6'd1) == total;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign element_kind   = kind_reg;
    assign element_number = number_reg;
    assign element_value  = value_reg;
    assign last_element   = last_reg;

endmodule

>>> design/gamepad_event_conditioner_unit.sv
// ----------------------------------------------------------------------------
// gamepad_event_conditioner_unit
// Gamepad event conditioner: keeps an axis and button snapshot and
// publishes it as a run of elements on tick or attach.
// ----------------------------------------------------------------------------
// One item is taken at a time. A button, tick without publication, attach
// of another device, detach or ignored event is accepted and then decoded;
// a hat event then writes its second slot; an axis event passes through the
// registered gain multiplier followed by the round, saturate and compare
// step. A publication reads each element (up to 32 elements) through the
// single registered read port of the axis slot store and loads it into the
// output register, waiting while out_ready is held low. The last element may
// sit in the output register while the next item is taken.
module gamepad_event_conditioner_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         mode,
    input  logic [7:0]         source_id,
    input  logic [7:0]         element_index,
    input  logic signed [15:0] sample_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               element_kind,
    output logic [3:0]         element_number,
    output logic signed [15:0] element_value,
    output logic               last_element
);

    gec_pkg::gec_cmd_t    cmd;
    gec_pkg::gec_status_t sts;

    gec_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gec_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .source_id      (source_id),
        .element_index  (element_index),
        .sample_value   (sample_value),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .element_kind   (element_kind),
        .element_number (element_number),
        .element_value  (element_value),
        .last_element   (last_element),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

>>> design/gec_checker.sv
// ----------------------------------------------------------------------------
// gec_checker
// Port-level checks for the gamepad event conditioner, bound to the top.
// ----------------------------------------------------------------------------
module gec_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               element_kind,
    input logic [3:0]         element_number,
    input logic signed [15:0] element_value,
    input logic               last_element
);

    // one item in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while previous one in progress");

    // axis values never reach the most negative code
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !element_kind |-> element_value != -16'sd32768)
        else $error("axis value out of range");

    // button values are 0 or 1
    a_button_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && element_kind |-> (element_value == 16'sd0 || element_value == 16'sd1))
        else $error("button value out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped before taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(element_kind) && $stable(element_number)
            && $stable(element_value) && $stable(last_element))
        else $error("stalled result item changed");

endmodule

bind gamepad_event_conditioner_unit gec_checker u_gec_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .element_kind   (element_kind),
    .element_number (element_number),
    .element_value  (element_value),
    .last_element   (last_element)
);
